>>> rtl/dpdunp_pkg.sv
// ----------------------------------------------------------------------------
// dpdunp_pkg: shared types and functions for the decimal128 DPD decoder
// Result class codes, field constants and the declet-to-BCD decode.
// ----------------------------------------------------------------------------
package dpdunp_pkg;

  typedef enum logic [2:0] {
    KIND_ZERO      = 3'd0,
    KIND_SUBNORMAL = 3'd1,
    KIND_NORMAL    = 3'd2,
    KIND_INFINITY  = 3'd3,
    KIND_SNAN      = 3'd4,
    KIND_QNAN      = 3'd5
  } kind_e;

  localparam int unsigned NumDeclets  = 11;
  localparam int unsigned DigitsWidth = 44;
  localparam int unsigned DeclWidth   = 10;
  localparam int unsigned BcdWidth    = 12;

  // exponent bias of decimal128
  localparam logic [13:0] ExpBias = 14'd6176;

  // unbiased exponent of a subnormal minimum (biased field zero)
  localparam logic signed [13:0] ExpMin = -14'sd6176;

  // combination field codes, taken from bits 6..2 of the top byte
  localparam logic [4:0] CombInfinity = 5'b11110;
  localparam logic [4:0] CombNan      = 5'b11111;

  // standard DPD decode; result is three BCD digits, most significant first
  function automatic logic [11:0] dpd_decode(input logic [9:0] b);
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    d0 = {1'b0, b[9:7]};
    d1 = {1'b0, b[6:4]};
    d2 = {1'b0, b[2:0]};
    if (b[3]) begin
      unique case (b[2:1])
        2'b00: begin
          d2 = {3'b100, b[0]};
        end
        2'b01: begin
          d1 = {3'b100, b[4]};
          d2 = {1'b0, b[6:5], b[0]};
        end
        2'b10: begin
          d0 = {3'b100, b[7]};
          d2 = {1'b0, b[9:8], b[0]};
        end
        default: begin
          unique case (b[6:5])
            2'b00: begin
              d0 = {3'b100, b[7]};
              d1 = {3'b100, b[4]};
              d2 = {1'b0, b[9:8], b[0]};
            end
            2'b01: begin
              d0 = {3'b100, b[7]};
              d1 = {1'b0, b[9:8], b[4]};
              d2 = {3'b100, b[0]};
            end
            2'b10: begin
              d1 = {3'b100, b[4]};
              d2 = {3'b100, b[0]};
            end
            default: begin
              d0 = {3'b100, b[7]};
              d1 = {3'b100, b[4]};
              d2 = {3'b100, b[0]};
            end
          endcase
        end
      endcase
    end
    return {d0, d1, d2};
  endfunction

  // the 24 redundant codes have all of bits 6,5,3,2,1 set and a nonzero top pair
  function automatic logic dpd_canonical(input logic [9:0] b);
    return !((b[6:5] == 2'b11) && (b[3:1] == 3'b111) && (b[9:8] != 2'b00));
  endfunction

endpackage

>>> rtl/decimal128_dpd_unpack.sv
// ----------------------------------------------------------------------------
// decimal128_dpd_unpack: decimal128 DPD word decoder
// Splits one 128-bit DPD encoded word into sign, class, exponent, lead digit,
// 33 trailing BCD digits and a canonical flag.
// ----------------------------------------------------------------------------
// pipeline: input register, then result register, with the decode logic
// between them
// throughput: one request per cycle while results are taken; a stalled result
// holds both stages, so the input stalls once two requests are held
// reset: asynchronous active-low reset clears both valid flags; data registers
// are not reset
module decimal128_dpd_unpack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        enc_high_i,
  input  logic [63:0]        enc_low_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sign_minus_o,
  output logic [2:0]         kind_o,
  output logic signed [13:0] exponent_o,
  output logic [3:0]         lead_digit_o,
  output logic [43:0]        digits_top_o,
  output logic [43:0]        digits_mid_o,
  output logic [43:0]        digits_bottom_o,
  output logic               all_canonical_o
);

  // stage 1: input register
  logic         s1_valid_q;
  logic [127:0] enc_q;
  logic         s1_advance;
  logic         s2_load;

  // stage 2: result register
  logic               out_valid_q;
  logic               sign_q;
  dpdunp_pkg::kind_e  kind_q;
  logic signed [13:0] exp_q;
  logic [3:0]         lead_q;
  logic [131:0]       bcd_q;
  logic               canon_q;

  // decode signals
  logic               sign_d;
  dpdunp_pkg::kind_e  kind_d;
  logic signed [13:0] exp_d;
  logic [3:0]         lead_d;
  logic [131:0]       bcd_d;
  logic               canon_d;
  logic [7:0]         top_byte;
  logic               comb_large;
  logic [13:0]        biased;
  logic [13:0]        unbiased;
  logic [3:0]         lead_raw;
  logic               trail_zero;
  logic [10:0]        canon_vec;

  assign s2_load    = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && s2_load;
  assign in_ready_o = !s1_valid_q || s2_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      enc_q <= {enc_high_i, enc_low_i};
    end
    if (s1_advance) begin
      sign_q  <= sign_d;
      kind_q  <= kind_d;
      exp_q   <= exp_d;
      lead_q  <= lead_d;
      bcd_q   <= bcd_d;
      canon_q <= canon_d;
    end
  end

  // combination field and exponent
  always_comb begin
    top_byte   = enc_q[127:120];
    comb_large = (top_byte[6:5] == 2'b11);
    biased     = {(comb_large ? top_byte[4:3] : top_byte[6:5]), enc_q[121:110]};
    unbiased   = biased - dpdunp_pkg::ExpBias;
    lead_raw   = comb_large ? {3'b100, top_byte[2]} : {1'b0, top_byte[4:2]};
    trail_zero = (enc_q[109:0] == 110'd0);
    sign_d     = enc_q[127];
  end

  // eleven declets, declet 0 is the most significant
  for (genvar i = 0; i < dpdunp_pkg::NumDeclets; i++) begin : g_declet
    localparam int unsigned DeclLsb = 100 - 10 * i;
    localparam int unsigned BcdMsb  = 131 - 12 * i;
    assign bcd_d[BcdMsb -: dpdunp_pkg::BcdWidth] =
        dpdunp_pkg::dpd_decode(enc_q[DeclLsb +: dpdunp_pkg::DeclWidth]);
    assign canon_vec[i] = dpdunp_pkg::dpd_canonical(enc_q[DeclLsb +: dpdunp_pkg::DeclWidth]);
  end

  assign canon_d = &canon_vec;

  always_comb begin
    exp_d  = unbiased;
    lead_d = lead_raw;
    priority if (top_byte[6:2] == dpdunp_pkg::CombInfinity) begin
      kind_d = dpdunp_pkg::KIND_INFINITY;
    end else if (top_byte[6:2] == dpdunp_pkg::CombNan) begin
      kind_d = top_byte[1] ? dpdunp_pkg::KIND_SNAN : dpdunp_pkg::KIND_QNAN;
    end else if (lead_raw == 4'd0 && trail_zero) begin
      kind_d = dpdunp_pkg::KIND_ZERO;
    end else if (lead_raw == 4'd0 && biased == 14'd0) begin
      // exponent + 33 at or below emin only happens at the smallest exponent
      kind_d = dpdunp_pkg::KIND_SUBNORMAL;
    end else begin
      kind_d = dpdunp_pkg::KIND_NORMAL;
    end
    if (kind_d == dpdunp_pkg::KIND_INFINITY || kind_d == dpdunp_pkg::KIND_SNAN ||
        kind_d == dpdunp_pkg::KIND_QNAN) begin
      exp_d  = 14'sd0;
      lead_d = 4'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sign_minus_o    = sign_q;
  assign kind_o          = kind_q;
  assign exponent_o      = exp_q;
  assign lead_digit_o    = lead_q;
  assign digits_top_o    = bcd_q[131:88];
  assign digits_mid_o    = bcd_q[87:44];
  assign digits_bottom_o = bcd_q[43:0];
  assign all_canonical_o = canon_q;

endmodule

>>> rtl/dpdunp_checker.sv
// ----------------------------------------------------------------------------
// dpdunp_checker: port-level checks for the decimal128 DPD decoder
// Watches the handshake and the consistency of class and result fields.
// ----------------------------------------------------------------------------
module dpdunp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               sign_minus_o,
  input logic [2:0]         kind_o,
  input logic signed [13:0] exponent_o,
  input logic [3:0]         lead_digit_o,
  input logic [43:0]        digits_top_o,
  input logic [43:0]        digits_mid_o,
  input logic [43:0]        digits_bottom_o,
  input logic               all_canonical_o
);

  // a stalled result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(sign_minus_o) && $stable(exponent_o) && $stable(digits_top_o) &&
    $stable(digits_mid_o) && $stable(digits_bottom_o) && $stable(all_canonical_o))
    else $error("result changed while stalled");

  // with the output side empty the pipeline always has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // special values carry no exponent or lead digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == dpdunp_pkg::KIND_INFINITY ||
    kind_o == dpdunp_pkg::KIND_SNAN || kind_o == dpdunp_pkg::KIND_QNAN)
    |-> exponent_o == 14'sd0 && lead_digit_o == 4'd0)
    else $error("special value with exponent or lead digit");

  // zero has no digits at all
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == dpdunp_pkg::KIND_ZERO |-> lead_digit_o == 4'd0 &&
    digits_top_o == 44'd0 && digits_mid_o == 44'd0 && digits_bottom_o == 44'd0)
    else $error("zero class with nonzero digits");

  // subnormal only at the smallest exponent with a zero lead digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == dpdunp_pkg::KIND_SUBNORMAL
    |-> lead_digit_o == 4'd0 && exponent_o == dpdunp_pkg::ExpMin)
    else $error("bad subnormal result");

endmodule

bind decimal128_dpd_unpack dpdunp_checker u_dpdunp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .sign_minus_o    (sign_minus_o),
  .kind_o          (kind_o),
  .exponent_o      (exponent_o),
  .lead_digit_o    (lead_digit_o),
  .digits_top_o    (digits_top_o),
  .digits_mid_o    (digits_mid_o),
  .digits_bottom_o (digits_bottom_o),
  .all_canonical_o (all_canonical_o)
);

>>> tb/tb_decimal128_dpd_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal128_dpd_unpack: self-checking bench for the decimal128 DPD decoder
// Offers encoded words over the request channel, predicts every decoded field
// in the bench, and compares each returned result in order.
// ----------------------------------------------------------------------------
module tb_decimal128_dpd_unpack;

  localparam int Dec128Bias     = 6176;
  localparam int Dec128Emin     = -6143;
  localparam int Dec128Prec     = 34;
  localparam int WatchdogLimit  = 2000;
  localparam int LongHoldCycles = 64;
  localparam int DrainCycles    = 10;

  typedef struct packed {
    logic               sign;
    dpdunp_pkg::kind_e  kind;
    logic signed [13:0] exponent;
    logic [3:0]         lead;
    logic [43:0]        top;
    logic [43:0]        mid;
    logic [43:0]        bottom;
    logic               canon;
  } dec_result_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    bit          typed;
    dec_result_t want;
  } word_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [63:0]        enc_high_i;
  logic [63:0]        enc_low_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               sign_minus_o;
  logic [2:0]         kind_o;
  logic signed [13:0] exponent_o;
  logic [3:0]         lead_digit_o;
  logic [43:0]        digits_top_o;
  logic [43:0]        digits_mid_o;
  logic [43:0]        digits_bottom_o;
  logic               all_canonical_o;

  dec_result_t pending_results[$];
  int          mismatch_cnt;
  int          requests_sent;
  int          results_seen;
  int          noncanon_seen;
  int          kind_seen[6];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  bit          long_hold_req;
  bit          long_hold_done;

  decimal128_dpd_unpack i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .enc_high_i     (enc_high_i),
    .enc_low_i      (enc_low_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sign_minus_o   (sign_minus_o),
    .kind_o         (kind_o),
    .exponent_o     (exponent_o),
    .lead_digit_o   (lead_digit_o),
    .digits_top_o   (digits_top_o),
    .digits_mid_o   (digits_mid_o),
    .digits_bottom_o(digits_bottom_o),
    .all_canonical_o(all_canonical_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one declet to three BCD digits, most significant first
  function automatic logic [11:0] declet_digits(input logic [9:0] b);
    logic [3:0] hi_d;
    logic [3:0] mid_d;
    logic [3:0] lo_d;
    hi_d  = {1'b0, b[9:7]};
    mid_d = {1'b0, b[6:4]};
    lo_d  = {1'b0, b[2:0]};
    if (b[3]) begin
      case (b[2:1])
        2'b00: begin
          lo_d = {3'b100, b[0]};
        end
        2'b01: begin
          mid_d = {3'b100, b[4]};
          lo_d  = {1'b0, b[6:5], b[0]};
        end
        2'b10: begin
          hi_d = {3'b100, b[7]};
          lo_d = {1'b0, b[9:8], b[0]};
        end
        default: begin
          case (b[6:5])
            2'b00: begin
              hi_d  = {3'b100, b[7]};
              mid_d = {3'b100, b[4]};
              lo_d  = {1'b0, b[9:8], b[0]};
            end
            2'b01: begin
              hi_d  = {3'b100, b[7]};
              mid_d = {1'b0, b[9:8], b[4]};
              lo_d  = {3'b100, b[0]};
            end
            2'b10: begin
              mid_d = {3'b100, b[4]};
              lo_d  = {3'b100, b[0]};
            end
            default: begin
              hi_d  = {3'b100, b[7]};
              mid_d = {3'b100, b[4]};
              lo_d  = {3'b100, b[0]};
            end
          endcase
        end
      endcase
    end
    return {hi_d, mid_d, lo_d};
  endfunction

  function automatic logic declet_is_canonical(input logic [9:0] b);
    return !(((b & 10'h06E) == 10'h06E) && ((b & 10'h300) != 10'h000));
  endfunction

  function automatic dec_result_t decode_dpd_word(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] w;
    logic [131:0] bcd;
    logic [13:0]  biased;
    logic [3:0]   lead;
    logic         lead_is_big;
    int           q;
    dec_result_t  r;
    w           = {hi, lo};
    lead_is_big = (w[126:125] == 2'b11);
    biased      = {lead_is_big ? w[124:123] : w[126:125], w[121:110]};
    lead        = lead_is_big ? {3'b100, w[122]} : {1'b0, w[124:122]};
    q           = int'(biased) - Dec128Bias;
    r.canon     = 1'b1;
    for (int i = 0; i < 11; i++) begin
      bcd[131 - 12*i -: 12] = declet_digits(w[109 - 10*i -: 10]);
      if (!declet_is_canonical(w[109 - 10*i -: 10])) r.canon = 1'b0;
    end
    r.sign   = w[127];
    r.top    = bcd[131:88];
    r.mid    = bcd[87:44];
    r.bottom = bcd[43:0];
    if (w[126:122] == dpdunp_pkg::CombInfinity) begin
      r.kind = dpdunp_pkg::KIND_INFINITY;
    end else if (w[126:122] == dpdunp_pkg::CombNan) begin
      r.kind = w[121] ? dpdunp_pkg::KIND_SNAN : dpdunp_pkg::KIND_QNAN;
    end else if (lead == 4'd0 && w[109:0] == '0) begin
      r.kind = dpdunp_pkg::KIND_ZERO;
    end else if (q + Dec128Prec - 1 <= Dec128Emin && lead == 4'd0) begin
      r.kind = dpdunp_pkg::KIND_SUBNORMAL;
    end else begin
      r.kind = dpdunp_pkg::KIND_NORMAL;
    end
    // exponent and lead digit are meaningless for infinity and nan
    if (r.kind == dpdunp_pkg::KIND_INFINITY || r.kind == dpdunp_pkg::KIND_SNAN ||
        r.kind == dpdunp_pkg::KIND_QNAN) begin
      r.exponent = '0;
      r.lead     = '0;
    end else begin
      r.exponent = biased - 14'd6176;
      r.lead     = lead;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    $display("%0t ns: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic offer_request(input logic [63:0] hi, input logic [63:0] lo, input bit typed,
                               input dec_result_t typed_want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    enc_high_i <= hi;
    enc_low_i  <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(typed ? typed_want : decode_dpd_word(hi, lo));
    requests_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic make_random_word(output logic [63:0] hi, output logic [63:0] lo);
    logic [127:0] w;
    logic [13:0]  biased;
    logic [3:0]   lead;
    int           sel;
    w      = {$urandom, $urandom, $urandom, $urandom};
    sel    = $urandom_range(0, 9);
    biased = 14'($urandom_range(0, 12287));
    lead   = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       biased = 14'd0;
        1:       biased = 14'd1;
        2:       biased = 14'd6176;
        default: biased = 14'd12287;
      endcase
    end
    // sel 0 and 1 keep the raw word with any combination field
    if (sel >= 2) begin
      if (sel == 6 || sel == 7) lead = 4'd0;
      if (sel == 7 && $urandom_range(0, 1) == 1) biased = 14'd0;
      if (sel == 6 || sel == 7 || sel == 9) begin
        w[109:0] = '0;
        if (sel != 6) w[10*$urandom_range(0, 10) +: 10] = 10'($urandom_range(1, 1023));
      end
      if (sel == 5) begin
        w[10*$urandom_range(0, 10) +: 10] = {2'($urandom_range(1, 3)), 1'($urandom), 2'b11,
                                             1'($urandom), 3'b111, 1'($urandom)};
      end
      if (lead > 4'd7) begin
        w[126:120] = {2'b11, biased[13:12], lead[0], biased[11:10]};
      end else begin
        w[126:120] = {biased[13:12], lead[2:0], biased[11:10]};
      end
      w[119:110] = biased[9:0];
      if (sel == 8) begin
        w[126:122] = $urandom_range(0, 1) ? dpdunp_pkg::CombInfinity : dpdunp_pkg::CombNan;
      end
    end
    hi = w[127:64];
    lo = w[63:0];
  endtask

  // receiver side, with one long hold-off so that the pipeline backs up
  initial begin : result_ready_driver
    int hold_left;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_ready_i    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        hold_left      = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    dec_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", {63'd0, 1'b1}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        kind_seen[int'(want.kind)]++;
        if (!want.canon) noncanon_seen++;
        if (sign_minus_o !== want.sign) report_mismatch("sign", 64'(sign_minus_o), 64'(want.sign));
        if (kind_o !== want.kind) report_mismatch("kind", 64'(kind_o), 64'(want.kind));
        if (exponent_o !== want.exponent) begin
          report_mismatch("exponent", 64'(exponent_o), 64'(want.exponent));
        end
        if (lead_digit_o !== want.lead) report_mismatch("lead", 64'(lead_digit_o), 64'(want.lead));
        if (digits_top_o !== want.top) begin
          report_mismatch("digits_top", 64'(digits_top_o), 64'(want.top));
        end
        if (digits_mid_o !== want.mid) begin
          report_mismatch("digits_mid", 64'(digits_mid_o), 64'(want.mid));
        end
        if (digits_bottom_o !== want.bottom) begin
          report_mismatch("digits_bottom", 64'(digits_bottom_o), 64'(want.bottom));
        end
        if (all_canonical_o !== want.canon) begin
          report_mismatch("canonical", 64'(all_canonical_o), 64'(want.canon));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    word_row_t   rows[$];
    logic [63:0] hi;
    logic [63:0] lo;
    int          phase_items;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    enc_high_i    = '0;
    enc_low_i     = '0;
    long_hold_req = 1'b0;
    mismatch_cnt  = 0;
    requests_sent = 0;
    results_seen  = 0;
    noncanon_seen = 0;
    quiet_cycles  = 0;
    send_idle_pct = 35;
    recv_idle_pct = 82;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    // hand-checked rows: zero, all ones, infinities and nans
    rows.push_back('{64'h0, 64'h0, 1'b1,
                     '{1'b0, dpdunp_pkg::KIND_ZERO, -14'sd6176, 4'd0, 44'h0, 44'h0, 44'h0,
                       1'b1}});
    rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                     '{1'b1, dpdunp_pkg::KIND_SNAN, 14'sd0, 4'd0, 44'h999_9999_9999,
                       44'h999_9999_9999, 44'h999_9999_9999, 1'b0}});
    rows.push_back('{64'h7800_0000_0000_0000, 64'h0, 1'b1,
                     '{1'b0, dpdunp_pkg::KIND_INFINITY, 14'sd0, 4'd0, 44'h0, 44'h0, 44'h0,
                       1'b1}});
    rows.push_back('{64'hF800_0000_0000_0000, 64'h0, 1'b1,
                     '{1'b1, dpdunp_pkg::KIND_INFINITY, 14'sd0, 4'd0, 44'h0, 44'h0, 44'h0,
                       1'b1}});
    rows.push_back('{64'h7C00_0000_0000_0000, 64'h0, 1'b1,
                     '{1'b0, dpdunp_pkg::KIND_QNAN, 14'sd0, 4'd0, 44'h0, 44'h0, 44'h0,
                       1'b1}});
    rows.push_back('{64'hFE00_0000_0000_0000, 64'h0, 1'b1,
                     '{1'b1, dpdunp_pkg::KIND_SNAN, 14'sd0, 4'd0, 44'h0, 44'h0, 44'h0,
                       1'b1}});
    rows.push_back('{64'h7C00_0000_0000_0000, 64'h1, 1'b1,
                     '{1'b0, dpdunp_pkg::KIND_QNAN, 14'sd0, 4'd0, 44'h0, 44'h0, 44'h1,
                       1'b1}});
    // zero at exponent 0, smallest subnormal, first normal exponent, top biased exponent
    rows.push_back('{64'h2208_0000_0000_0000, 64'h0, 1'b0, '0});
    rows.push_back('{64'h0, 64'h1, 1'b0, '0});
    rows.push_back('{64'h0000_4000_0000_0000, 64'h1, 1'b0, '0});
    rows.push_back('{64'h5FFF_ED09_BEAD_87C0, 64'h378D_8E63_FFFF_FFFF, 1'b0, '0});
    // negative zero, zero at the top exponent, lead digits 8 and 9
    rows.push_back('{64'h8000_0000_0000_0000, 64'h0, 1'b0, '0});
    rows.push_back('{64'h43FF_C000_0000_0000, 64'h0, 1'b0, '0});
    rows.push_back('{64'h6208_0000_0000_0000, 64'h1, 1'b0, '0});
    rows.push_back('{64'h77FF_C000_0000_0000, 64'h123, 1'b0, '0});
    // every branch of the declet decode, redundant codes included
    rows.push_back('{64'h2208_0000_0000_0000, 64'h1A5, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h009, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h05B, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h1AD, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h28F, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h0AE, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h1CF, 1'b0, '0});
    rows.push_back('{64'h2208_0000_0000_0000, 64'h1BBFE, 1'b0, '0});
    rows.push_back('{64'h2208_16E0_0000_0000, 64'h0, 1'b0, '0});
    // declet straddling the two halves
    rows.push_back('{64'h2208_0000_0000_003F, 64'hF000_0000_0000_0000, 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) offer_request(rows[r].hi, rows[r].lo, rows[r].typed, rows[r].want);
    wait_all_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 82;
          phase_items   = 420;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 35;
          phase_items   = 420;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          phase_items   = 410;
        end
      endcase
      for (int n = 0; n < phase_items; n++) begin
        if (phase == 2 && n == 100) long_hold_req = 1'b1;
        make_random_word(hi, lo);
        offer_request(hi, lo, 1'b0, '0);
      end
      // sender stays quiet until the block has returned everything
      wait_all_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);
    end
    $display("covered %0d requests over three idling mixes, %0d results checked, %0d mismatches",
             requests_sent, results_seen, mismatch_cnt);
    $display("classes: zero %0d subnormal %0d normal %0d inf %0d snan %0d qnan %0d,",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5]);
    $display("  %0d non-canonical", noncanon_seen);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
